[hw/rtl/lct_pkg.sv]
// ---------------------------------------------------------------------------
// Lock contention tracker package
// Table sizes, record layouts, codes and the command and status groups that
// pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package lct_pkg;

   localparam int THREAD_ENTRIES = 32;
   localparam int LOCK_ENTRIES   = 64;
   localparam int TIDX_W         = $clog2(THREAD_ENTRIES);
   localparam int LIDX_W         = $clog2(LOCK_ENTRIES);

   typedef logic [TIDX_W-1:0] tidx_type;
   typedef logic [LIDX_W-1:0] lidx_type;

   typedef enum logic [2:0] {
      ACT_LOCK_ENTER = 3'd0,
      ACT_LOCK_EXIT  = 3'd1,
      ACT_UNLOCK     = 3'd2,
      ACT_TRY_OK     = 3'd3,
      ACT_TRY_FAIL   = 3'd4,
      ACT_CLEAR      = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      ST_APPLIED     = 2'd0,
      ST_NO_EFFECT   = 2'd1,
      ST_THREAD_FULL = 2'd2,
      ST_LOCK_FULL   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MATCH,
      S_ALLOC,
      S_FETCH,
      S_EXIT_FETCH,
      S_EXEC
   } state_type;

   typedef struct packed {
      logic        pending;
      logic        armed;
      lidx_type    pend_slot;
      logic [63:0] wait_begin;
      logic [63:0] wait_sum;
      logic [63:0] hold_sum;
      logic [31:0] contended;
      logic [31:0] acquired;
   } thread_rec_type;

   typedef struct packed {
      logic        holder_valid;
      tidx_type    holder_slot;
      logic [63:0] hold_begin;
      logic [63:0] wait_sum;
      logic [63:0] hold_sum;
      logic [31:0] contended;
      logic [31:0] acquired;
   } lock_rec_type;

   typedef struct packed {
      logic capture;
      logic match;
      logic alloc;
      logic fetch;
      logic exit_fetch;
      logic exec;
   } ctrl_cmd_type;

   typedef struct packed {
      logic exit_path;
      logic out_busy;
   } dp_stat_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] wait_measured;
      logic [63:0] hold_measured;
      logic [63:0] thread_wait_sum;
      logic [63:0] thread_hold_sum;
      logic [31:0] thread_contended;
      logic [31:0] thread_acquired;
      logic [63:0] lock_wait_sum;
      logic [63:0] lock_hold_sum;
      logic [31:0] lock_contended;
      logic [31:0] lock_acquired;
      logic        lock_is_held;
   } resp_type;

   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return (s < a) ? '1 : s;
   endfunction

   function automatic logic [31:0] sat_inc32(input logic [31:0] a);
      return (a == '1) ? a : a + 32'd1;
   endfunction

   // Lowest set bit wins.
   function automatic tidx_type enc_thread(input logic [THREAD_ENTRIES-1:0] vec);
      tidx_type r;
      r = '0;
      for (int i = THREAD_ENTRIES - 1; i >= 0; i--) begin
         if (vec[i]) r = TIDX_W'(i);
      end
      return r;
   endfunction

   function automatic lidx_type enc_lock(input logic [LOCK_ENTRIES-1:0] vec);
      lidx_type r;
      r = '0;
      for (int i = LOCK_ENTRIES - 1; i >= 0; i--) begin
         if (vec[i]) r = LIDX_W'(i);
      end
      return r;
   endfunction

endpackage

[hw/rtl/lct_req_if.sv]
// ---------------------------------------------------------------------------
// Lock contention tracker event channel
// Valid/ready channel that carries one mutex event per transaction.
// ---------------------------------------------------------------------------
interface lct_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [31:0] thread_id;
   logic [63:0] lock_address;
   logic [63:0] event_time;

   modport source (output valid, action, thread_id, lock_address, event_time,
                   input ready);
   modport sink   (input valid, action, thread_id, lock_address, event_time,
                   output ready);
endinterface

[hw/rtl/lct_rsp_if.sv]
// ---------------------------------------------------------------------------
// Lock contention tracker result channel
// Valid/ready channel that carries one result per transaction.
// ---------------------------------------------------------------------------
interface lct_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [63:0] wait_measured;
   logic [63:0] hold_measured;
   logic [63:0] thread_wait_sum;
   logic [63:0] thread_hold_sum;
   logic [31:0] thread_contended;
   logic [31:0] thread_acquired;
   logic [63:0] lock_wait_sum;
   logic [63:0] lock_hold_sum;
   logic [31:0] lock_contended;
   logic [31:0] lock_acquired;
   logic        lock_is_held;

   modport source (output valid, status, wait_measured, hold_measured, thread_wait_sum,
                   thread_hold_sum, thread_contended, thread_acquired, lock_wait_sum,
                   lock_hold_sum, lock_contended, lock_acquired, lock_is_held,
                   input ready);
   modport sink   (input valid, status, wait_measured, hold_measured, thread_wait_sum,
                   thread_hold_sum, thread_contended, thread_acquired, lock_wait_sum,
                   lock_hold_sum, lock_contended, lock_acquired, lock_is_held,
                   output ready);
endinterface

[hw/rtl/lct_ram.sv]
// ---------------------------------------------------------------------------
// Lock contention tracker RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module lct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[hw/rtl/lct_controller.sv]
// ---------------------------------------------------------------------------
// Lock contention tracker controller
// Sequences one event through match, allocation, fetch, exit fetch where needed, and execute steps.
// ---------------------------------------------------------------------------
module lct_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lct_pkg::dp_stat_type stat,
   output lct_pkg::ctrl_cmd_type cmd
);
   import lct_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:       if (req_valid) state_in = S_MATCH;
         S_MATCH:      state_in = S_ALLOC;
         S_ALLOC:      state_in = S_FETCH;
         S_FETCH:      state_in = stat.exit_path ? S_EXIT_FETCH : S_EXEC;
         S_EXIT_FETCH: state_in = S_EXEC;
         S_EXEC:       if (!stat.out_busy) state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_MATCH:      cmd.match      = 1'b1;
         S_ALLOC:      cmd.alloc      = 1'b1;
         S_FETCH:      cmd.fetch      = 1'b1;
         S_EXIT_FETCH: cmd.exit_fetch = 1'b1;
         S_EXEC:       cmd.exec       = !stat.out_busy;
         default:      cmd            = '0;
      endcase
   end
endmodule

[hw/rtl/lct_datapath.sv]
// ---------------------------------------------------------------------------
// Lock contention tracker datapath
// Tag match arrays, thread and mutex record RAMs, update logic and the
// result register.
// ---------------------------------------------------------------------------
module lct_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  lct_pkg::ctrl_cmd_type cmd,
   output lct_pkg::dp_stat_type  stat,
   input  logic [2:0]            req_action,
   input  logic [31:0]           req_thread_id,
   input  logic [63:0]           req_lock_address,
   input  logic [63:0]           req_event_time,
   lct_rsp_if.source             rsp_chan
);
   import lct_pkg::*;

   logic [2:0]  act_ff;
   logic [31:0] tid_ff;
   logic [63:0] addr_ff, now_ff;

   logic [THREAD_ENTRIES-1:0] t_used_ff, t_used_in, t_hit_ff, t_hit_in;
   logic [LOCK_ENTRIES-1:0]   l_used_ff, l_used_in, l_hit_ff, l_hit_in;
   logic [31:0] t_tag_ff [THREAD_ENTRIES];
   logic [63:0] l_tag_ff [LOCK_ENTRIES];

   tidx_type       t_idx_ff, t_idx_enc;
   lidx_type       l_idx_ff, l_idx_enc, l_raddr;
   logic           t_fresh_ff, l_fresh_ff, bypass_ff;
   status_type     byp_code_ff, byp_code;
   thread_rec_type t_rec_ff, t_rdata, t_new;
   lock_rec_type   l_rec_ff, l_rdata, l_new;
   logic [63:0]    wait_diff_ff, hold_diff_ff;
   resp_type       out_ff, out_in;
   logic           rsp_valid_ff;

   logic need_t, need_m, t_found, l_found, t_full, l_full, bypass, t_alloc, l_alloc;
   logic touch_t, touch_l, is_holder;
   status_type  st;
   logic [63:0] wm, hm;

   // Event capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff  <= req_action;
         tid_ff  <= req_thread_id;
         addr_ff <= req_lock_address;
         now_ff  <= req_event_time;
      end
   end

   assign need_t = (act_ff == ACT_LOCK_ENTER) || (act_ff == ACT_LOCK_EXIT) ||
                   (act_ff == ACT_UNLOCK) || (act_ff == ACT_TRY_OK);
   assign need_m = (act_ff == ACT_LOCK_ENTER) || (act_ff == ACT_UNLOCK) ||
                   (act_ff == ACT_TRY_OK) || (act_ff == ACT_TRY_FAIL);

   // Parallel tag compare; the match vectors are registered before encoding.
   always_comb begin
      for (int i = 0; i < THREAD_ENTRIES; i++)
         t_hit_in[i] = t_used_ff[i] && (t_tag_ff[i] == tid_ff);
      for (int j = 0; j < LOCK_ENTRIES; j++)
         l_hit_in[j] = l_used_ff[j] && (l_tag_ff[j] == addr_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.match) begin
         t_hit_ff <= t_hit_in;
         l_hit_ff <= l_hit_in;
      end
   end

   assign t_found   = |t_hit_ff;
   assign l_found   = |l_hit_ff;
   assign t_full    = !t_found && (&t_used_ff);
   assign l_full    = !l_found && (&l_used_ff);
   assign t_idx_enc = t_found ? enc_thread(t_hit_ff) : enc_thread(~t_used_ff);
   assign l_idx_enc = l_found ? enc_lock(l_hit_ff) : enc_lock(~l_used_ff);

   // Events that skip the tables: unused codes, clear, and full tables.
   always_comb begin
      bypass   = 1'b1;
      byp_code = ST_APPLIED;
      if (act_ff > ACT_CLEAR) byp_code = ST_NO_EFFECT;
      else if (act_ff == ACT_CLEAR) byp_code = ST_APPLIED;
      else if (need_t && t_full) byp_code = ST_THREAD_FULL;
      else if (need_m && l_full) byp_code = ST_LOCK_FULL;
      else bypass = 1'b0;
   end

   assign t_alloc = !bypass && need_t && !t_found;
   assign l_alloc = !bypass && need_m && !l_found;

   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         t_idx_ff    <= t_idx_enc;
         l_idx_ff    <= l_idx_enc;
         t_fresh_ff  <= !t_found;
         l_fresh_ff  <= !l_found;
         bypass_ff   <= bypass;
         byp_code_ff <= byp_code;
      end else if (cmd.exit_fetch) begin
         l_idx_ff <= t_rec_ff.pend_slot;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < THREAD_ENTRIES; i++)
         if (cmd.alloc && t_alloc && (t_idx_enc == TIDX_W'(i))) t_tag_ff[i] <= tid_ff;
      for (int j = 0; j < LOCK_ENTRIES; j++)
         if (cmd.alloc && l_alloc && (l_idx_enc == LIDX_W'(j))) l_tag_ff[j] <= addr_ff;
   end

   always_comb begin
      t_used_in = t_used_ff;
      l_used_in = l_used_ff;
      if (cmd.alloc && t_alloc) t_used_in[t_idx_enc] = 1'b1;
      if (cmd.alloc && l_alloc) l_used_in[l_idx_enc] = 1'b1;
      if (cmd.exec && (act_ff == ACT_CLEAR)) begin
         t_used_in = '0;
         l_used_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_used_ff <= '0;
         l_used_ff <= '0;
      end else begin
         t_used_ff <= t_used_in;
         l_used_ff <= l_used_in;
      end
   end

   // During fetch the mutex RAM is re-read at the slot a lock exit waits on.
   assign l_raddr = cmd.fetch ? t_rdata.pend_slot : l_idx_enc;

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         t_rec_ff     <= t_fresh_ff ? '0 : t_rdata;
         l_rec_ff     <= l_fresh_ff ? '0 : l_rdata;
         wait_diff_ff <= now_ff - t_rdata.wait_begin;
         hold_diff_ff <= now_ff - l_rdata.hold_begin;
      end else if (cmd.exit_fetch) begin
         l_rec_ff <= l_rdata;
      end
   end

   assign stat.exit_path = (act_ff == ACT_LOCK_EXIT) && !bypass_ff && !t_fresh_ff &&
                           t_rdata.pending;
   assign stat.out_busy  = rsp_valid_ff && !rsp_chan.ready;

   assign is_holder = l_rec_ff.holder_valid && (l_rec_ff.holder_slot == t_idx_ff);

   always_comb begin
      t_new   = t_rec_ff;
      l_new   = l_rec_ff;
      st      = ST_APPLIED;
      wm      = '0;
      hm      = '0;
      touch_t = need_t;
      touch_l = need_m;
      case (act_ff)
         ACT_LOCK_ENTER: begin
            t_new.pending    = 1'b1;
            t_new.pend_slot  = l_idx_ff;
            t_new.armed      = l_rec_ff.holder_valid;
            t_new.wait_begin = now_ff;
         end
         ACT_LOCK_EXIT: begin
            if (!t_rec_ff.pending) begin
               st      = ST_NO_EFFECT;
               touch_l = 1'b0;
            end else begin
               touch_l = 1'b1;
               if (t_rec_ff.armed) wm = wait_diff_ff;
               if (wm != '0) begin
                  t_new.wait_sum  = sat_add64(t_rec_ff.wait_sum, wm);
                  l_new.wait_sum  = sat_add64(l_rec_ff.wait_sum, wm);
                  t_new.contended = sat_inc32(t_rec_ff.contended);
                  l_new.contended = sat_inc32(l_rec_ff.contended);
               end
               t_new.pending      = 1'b0;
               t_new.armed        = 1'b0;
               l_new.holder_valid = 1'b1;
               l_new.holder_slot  = t_idx_ff;
               l_new.hold_begin   = now_ff;
               t_new.acquired     = sat_inc32(t_rec_ff.acquired);
               l_new.acquired     = sat_inc32(l_rec_ff.acquired);
            end
         end
         ACT_UNLOCK: begin
            if (is_holder) begin
               hm                 = hold_diff_ff;
               t_new.hold_sum     = sat_add64(t_rec_ff.hold_sum, hm);
               l_new.hold_sum     = sat_add64(l_rec_ff.hold_sum, hm);
               l_new.holder_valid = 1'b0;
            end else begin
               st = ST_NO_EFFECT;
            end
         end
         ACT_TRY_OK: begin
            if (is_holder) begin
               st = ST_NO_EFFECT;
            end else begin
               l_new.holder_valid = 1'b1;
               l_new.holder_slot  = t_idx_ff;
               l_new.hold_begin   = now_ff;
               t_new.acquired     = sat_inc32(t_rec_ff.acquired);
               l_new.acquired     = sat_inc32(l_rec_ff.acquired);
            end
         end
         ACT_TRY_FAIL: l_new.contended = sat_inc32(l_rec_ff.contended);
         default: begin
            touch_t = 1'b0;
            touch_l = 1'b0;
         end
      endcase
   end

   always_comb begin
      out_in = '0;
      if (bypass_ff) begin
         out_in.status = byp_code_ff;
      end else begin
         out_in.status        = st;
         out_in.wait_measured = wm;
         out_in.hold_measured = hm;
         if (touch_t) begin
            out_in.thread_wait_sum  = t_new.wait_sum;
            out_in.thread_hold_sum  = t_new.hold_sum;
            out_in.thread_contended = t_new.contended;
            out_in.thread_acquired  = t_new.acquired;
         end
         if (touch_l) begin
            out_in.lock_wait_sum  = l_new.wait_sum;
            out_in.lock_hold_sum  = l_new.hold_sum;
            out_in.lock_contended = l_new.contended;
            out_in.lock_acquired  = l_new.acquired;
            out_in.lock_is_held   = l_new.holder_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset)                 rsp_valid_ff <= 1'b0;
      else if (cmd.exec)         rsp_valid_ff <= 1'b1;
      else if (rsp_chan.ready)   rsp_valid_ff <= 1'b0;
   end

   lct_ram #(.WIDTH($bits(thread_rec_type)), .DEPTH(THREAD_ENTRIES)) u_thread_ram (
      .clock (clock),
      .we    (cmd.exec && !bypass_ff && touch_t),
      .waddr (t_idx_ff),
      .wdata (t_new),
      .raddr (t_idx_enc),
      .rdata (t_rdata)
   );

   lct_ram #(.WIDTH($bits(lock_rec_type)), .DEPTH(LOCK_ENTRIES)) u_lock_ram (
      .clock (clock),
      .we    (cmd.exec && !bypass_ff && touch_l),
      .waddr (l_idx_ff),
      .wdata (l_new),
      .raddr (l_raddr),
      .rdata (l_rdata)
   );

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = out_ff.status;
   assign rsp_chan.wait_measured    = out_ff.wait_measured;
   assign rsp_chan.hold_measured    = out_ff.hold_measured;
   assign rsp_chan.thread_wait_sum  = out_ff.thread_wait_sum;
   assign rsp_chan.thread_hold_sum  = out_ff.thread_hold_sum;
   assign rsp_chan.thread_contended = out_ff.thread_contended;
   assign rsp_chan.thread_acquired  = out_ff.thread_acquired;
   assign rsp_chan.lock_wait_sum    = out_ff.lock_wait_sum;
   assign rsp_chan.lock_hold_sum    = out_ff.lock_hold_sum;
   assign rsp_chan.lock_contended   = out_ff.lock_contended;
   assign rsp_chan.lock_acquired    = out_ff.lock_acquired;
   assign rsp_chan.lock_is_held     = out_ff.lock_is_held;
endmodule

[hw/rtl/lock_contention_tracker.sv]
// ---------------------------------------------------------------------------
// Lock contention tracker
// Tracks mutex wait and hold times per thread and per mutex.
//
//   Channel    Direction  Transaction
//   req_chan   in         one mutex event (action, thread, address, time)
//   rsp_chan   out        one result per event (status, times, totals)
//
// The result of an event is registered after its match, allocation, fetch
// and execute steps; a lock exit that finds a pending wait adds an exit
// fetch step, since the awaited mutex record is read from its RAM only after
// the thread record is back. Tag match, slot encode and each record RAM read
// end in a register. Reset clears the slot-used bits; record RAMs need no
// clearing. A new event is taken once the last leaves execute, also while its
// result waits; a stalled result holds the execute step of the next event.
// ---------------------------------------------------------------------------
module lock_contention_tracker (
   input  logic      clock,
   input  logic      reset,
   lct_req_if.sink   req_chan,
   lct_rsp_if.source rsp_chan
);
   import lct_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;
   logic         req_ready;

   assign req_chan.ready = req_ready;

   lct_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lct_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_action       (req_chan.action),
      .req_thread_id    (req_chan.thread_id),
      .req_lock_address (req_chan.lock_address),
      .req_event_time   (req_chan.event_time),
      .rsp_chan         (rsp_chan)
   );

   // The controller issues at most one step command per cycle.
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.match, cmd.alloc, cmd.fetch, cmd.exit_fetch, cmd.exec}))
      else $error("more than one step command active");

   // An accepted transaction starts its tag match in the next cycle.
   a_match_follows: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> cmd.match)
      else $error("tag match did not follow accepted transaction");

   // Allocation is always followed by the record fetch.
   a_fetch_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc |=> cmd.fetch)
      else $error("fetch did not follow allocation");

   // Executing an event always presents a result.
   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_chan.valid)
      else $error("no result after execute");
endmodule
